FILE: rtl/core/generational_handle_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Shorthand for the concurrent checks on the allocator ports.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH

// Check that is switched off while reset is high.
`define GHA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("handle allocator check failed");

// Check that also holds across reset.
`define GHA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("handle allocator reset check failed");

`endif

FILE: rtl/core/gha_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Sizes, request and status codes, and the write port types of the tables.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int SLOT_COUNT = 256;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int GEN_W      = 16;

   localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_COUNT);
   localparam logic [GEN_W-1:0] GEN_NONE   = '0;
   localparam logic [GEN_W-1:0] GEN_FIRST  = GEN_W'(1);

   // request codes
   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_ERASE  = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_STALE     = 2'd2;
   localparam logic [1:0] ST_ATTACHED  = 2'd3;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [GEN_W-1:0]  data;
   } gen_wr_type;

   // a freed slot is stacked together with its already advanced generation
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [GEN_W-1:0]  gen;
   } stack_entry_type;

   typedef struct packed {
      logic            en;
      logic [SLOT_W-1:0] addr;
      stack_entry_type data;
   } stack_wr_type;

endpackage

FILE: rtl/core/gha_gen_table.sv
// ----------------------------------------------------------------------------
// Generation table
// Per-slot generation memory; unwritten slots read as generation one.
// ----------------------------------------------------------------------------
module gha_gen_table (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [gha_pkg::SLOT_W-1:0] rd_addr,
   input  gha_pkg::gen_wr_type      wr,
   output logic [gha_pkg::GEN_W-1:0]  rd_data
);
   import gha_pkg::*;

   logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] written_ff;
   logic [GEN_W-1:0]      rd_raw_ff;
   logic                  rd_written_ff;
   logic                  fwd;

   // write and read of the same slot in one cycle: take the new value
   assign fwd = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         gen_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_raw_ff     <= fwd ? wr.data : gen_mem[rd_addr];
         rd_written_ff <= fwd | written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_written_ff ? rd_raw_ff : GEN_FIRST;

endmodule

FILE: rtl/core/gha_free_stack.sv
// ----------------------------------------------------------------------------
// Free slot stack
// LIFO storage of freed slots with a registered top-of-stack read.
// ----------------------------------------------------------------------------
module gha_free_stack (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [gha_pkg::SLOT_W-1:0]  rd_addr,
   input  gha_pkg::stack_wr_type       wr,
   output gha_pkg::stack_entry_type    rd_data
);
   import gha_pkg::*;

   stack_entry_type stack_mem [SLOT_COUNT];
   stack_entry_type rd_ff;
   logic            fwd;

   assign fwd = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         stack_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_ff <= fwd ? wr.data : stack_mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

FILE: rtl/core/generational_handle_allocator_top.sv
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out (slot, generation) handles, retires them and checks liveness.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid / req_stall): req_type selects create, erase
//    or lookup; erase and lookup name a handle by slot and generation, and
//    req_still_attached refuses an erase of an entry that is still in use.
//  - Response channel (rsp_valid / rsp_stall): one beat per request, in
//    order, carrying a status plus the created or echoed handle.
//  - Pipeline: an accepted request enters the execute register, and its
//    response is then registered in the response register and presented.
//  - Throughput: one request per cycle while rsp_stall holds no response. The execute stage holds the request
//    while the generation table and the free stack deliver their registered
//    reads; results from the item ahead are forwarded into those reads.
//  - Back pressure: when rsp_stall holds a response, the execute stage keeps
//    its request and req_stall rises only if that stage is also occupied.
//  - Reset (synchronous): empties both stages, all slots unused, free stack
//    empty, every generation reads as one. No sweep is needed.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_type,
   input  logic [gha_pkg::SLOT_W-1:0] req_handle_slot,
   input  logic [gha_pkg::GEN_W-1:0]  req_handle_generation,
   input  logic                       req_still_attached,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [gha_pkg::SLOT_W-1:0] rsp_out_slot,
   output logic [gha_pkg::GEN_W-1:0]  rsp_out_generation
);
   import gha_pkg::*;

   // execute stage
   logic              s1_valid_ff;
   logic [1:0]        s1_type_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [GEN_W-1:0]  s1_gen_ff;
   logic              s1_att_ff;

   // response register
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [GEN_W-1:0]  rsp_gen_ff, rsp_gen_in;

   // allocator state
   logic [CNT_W-1:0]      free_count_ff, free_count_in;
   logic [CNT_W-1:0]      high_water_ff, high_water_in;
   logic [SLOT_COUNT-1:0] occupied_ff;

   logic              accept;
   logic              advance;
   logic              live;
   logic [GEN_W-1:0]  gen_cur;
   logic [GEN_W-1:0]  gen_inc;
   logic [GEN_W-1:0]  gen_next;
   logic              occ_set, occ_clr;
   logic [SLOT_W-1:0] occ_addr;
   logic [SLOT_W-1:0] stack_rd_addr;
   logic [CNT_W-1:0]  count_less_one;
   gen_wr_type        gen_wr;
   stack_wr_type      stack_wr;
   stack_entry_type   stack_top;

   // execute stage moves on when the response register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // ---- table reads, issued at accept ----
   // the stack top after this cycle's pop or push
   assign count_less_one = free_count_in - CNT_W'(1);
   assign stack_rd_addr  = count_less_one[SLOT_W-1:0];

   gha_gen_table u_gen_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_handle_slot),
      .wr      (gen_wr),
      .rd_data (gen_cur)
   );

   gha_free_stack u_free_stack (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (stack_rd_addr),
      .wr      (stack_wr),
      .rd_data (stack_top)
   );

   // ---- execute ----
   assign live = (s1_gen_ff != GEN_NONE)
              && ({1'b0, s1_slot_ff} < high_water_ff)
              && occupied_ff[s1_slot_ff]
              && (gen_cur == s1_gen_ff);

   // advance the generation, wrapping past zero to one
   assign gen_inc  = gen_cur + GEN_W'(1);
   assign gen_next = (gen_inc == GEN_NONE) ? GEN_FIRST : gen_inc;

   always_comb begin
      rsp_status_in = ST_OK;
      rsp_slot_in   = s1_slot_ff;
      rsp_gen_in    = s1_gen_ff;
      free_count_in = free_count_ff;
      high_water_in = high_water_ff;
      occ_set       = 1'b0;
      occ_clr       = 1'b0;
      occ_addr      = s1_slot_ff;
      gen_wr        = '0;
      stack_wr      = '0;

      if (advance) begin
         case (s1_type_ff)
            REQ_CREATE: begin
               if (free_count_ff != '0) begin
                  // reuse the most recently freed slot
                  free_count_in = free_count_ff - CNT_W'(1);
                  rsp_slot_in   = stack_top.slot;
                  rsp_gen_in    = stack_top.gen;
                  occ_set       = 1'b1;
                  occ_addr      = stack_top.slot;
               end else if (high_water_ff < SLOT_LIMIT) begin
                  // fresh slot, never erased, so still at generation one
                  high_water_in = high_water_ff + CNT_W'(1);
                  rsp_slot_in   = high_water_ff[SLOT_W-1:0];
                  rsp_gen_in    = GEN_FIRST;
                  occ_set       = 1'b1;
                  occ_addr      = high_water_ff[SLOT_W-1:0];
               end else begin
                  rsp_status_in = ST_EXHAUSTED;
                  rsp_slot_in   = '0;
                  rsp_gen_in    = GEN_NONE;
               end
            end
            REQ_ERASE: begin
               if (!live) begin
                  rsp_status_in = ST_STALE;
               end else if (s1_att_ff) begin
                  rsp_status_in = ST_ATTACHED;
               end else begin
                  occ_clr     = 1'b1;
                  gen_wr.en   = 1'b1;
                  gen_wr.addr = s1_slot_ff;
                  gen_wr.data = gen_next;
                  if (free_count_ff < SLOT_LIMIT) begin
                     stack_wr.en        = 1'b1;
                     stack_wr.addr      = free_count_ff[SLOT_W-1:0];
                     stack_wr.data.slot = s1_slot_ff;
                     stack_wr.data.gen  = gen_next;
                     free_count_in      = free_count_ff + CNT_W'(1);
                  end
               end
            end
            REQ_LOOKUP: begin
               rsp_status_in = live ? ST_OK : ST_STALE;
            end
            default: begin
               // unused code behaves as a lookup
               rsp_status_in = live ? ST_OK : ST_STALE;
            end
         endcase
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         free_count_ff <= '0;
         high_water_ff <= '0;
         occupied_ff   <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         free_count_ff <= free_count_in;
         high_water_ff <= high_water_in;
         if (occ_set) begin
            occupied_ff[occ_addr] <= 1'b1;
         end else if (occ_clr) begin
            occupied_ff[occ_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff <= req_type;
         s1_slot_ff <= req_handle_slot;
         s1_gen_ff  <= req_handle_generation;
         s1_att_ff  <= req_still_attached;
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_gen_ff    <= rsp_gen_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_slot       = rsp_slot_ff;
   assign rsp_out_generation = rsp_gen_ff;

endmodule

FILE: rtl/core/gha_checker.sv
// ----------------------------------------------------------------------------
// Generational handle allocator port checker
// Port-level checks on responses, bound to the allocator top level.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_top_macros.svh"

module gha_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_status,
   input logic [gha_pkg::SLOT_W-1:0] rsp_out_slot,
   input logic [gha_pkg::GEN_W-1:0]  rsp_out_generation
);
   import gha_pkg::*;

   logic                    ok_beat;
   logic                    exh_beat;
   logic                    null_handle;
   logic [1+SLOT_W+GEN_W:0] rsp_beat;

   assign ok_beat     = rsp_valid && (rsp_status == ST_OK);
   assign exh_beat    = rsp_valid && (rsp_status == ST_EXHAUSTED);
   assign null_handle = (rsp_out_slot == '0) && (rsp_out_generation == GEN_NONE);
   assign rsp_beat    = {rsp_status, rsp_out_slot, rsp_out_generation};

   // no response beat right after reset
   `GHA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // a good result always names a nonzero generation
   `GHA_ASSERT(a_ok_gen_nonzero, clock, reset, ok_beat |-> rsp_out_generation != GEN_NONE)

   // a failed create returns the null handle
   `GHA_ASSERT(a_exhausted_null, clock, reset, exh_beat |-> null_handle)

   // a stalled response beat stays put
   `GHA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Walks a short directed table after reset, fills the table to exhaustion
// and then runs four randomized traffic phases (drain and fill biased)
// under varying request gaps and response stalls.
// Every response beat is compared field by field with an in-order queue of
// expected beats, typed in or computed by a local model of the handle table.
// ----------------------------------------------------------------------------
module tb;
   import gha_pkg::*;

   // unused request code; the block decodes it as a lookup
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam int HOLD_CYCLES = 80;   // long response hold-off for back pressure
   localparam int PHASE_ITEMS = 380;  // random requests per phase
   localparam int DRAIN_WAIT  = 2000; // cycles allowed for the last responses

   // sender gap and receiver stall odds (percent) of the random phases
   localparam int GAP_PCT   [4] = '{0, 67, 0, 22};
   localparam int STALL_PCT [4] = '{0, 0, 67, 22};

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [GEN_W-1:0]  gen;
      logic              attached;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [GEN_W-1:0]  gen;
   } alloc_rsp_type;

   // directed row: request, whether the response is typed in, typed response
   typedef struct packed {
      alloc_req_type req;
      logic          typed;
      alloc_rsp_type rsp;
   } dir_row_type;

   // Directed table, run right after reset. Slots are handed out in order
   // 0, 1, 2 ... while nothing has been freed; freed slots come back LIFO.
   localparam dir_row_type DIR_TABLE [20] = '{
      // nothing created yet: every handle is stale
      '{'{REQ_LOOKUP, 8'd0,   16'd1,     1'b0}, 1'b1, '{ST_STALE,  8'd0,   16'd1}},
      '{'{REQ_ERASE,  8'd255, 16'hFFFF,  1'b1}, 1'b1, '{ST_STALE,  8'd255, 16'hFFFF}},
      // first two creates take fresh slots at generation one
      '{'{REQ_CREATE, 8'd0,   16'd0,     1'b0}, 1'b1, '{ST_OK,     8'd0,   16'd1}},
      '{'{REQ_CREATE, 8'd0,   16'd0,     1'b0}, 1'b1, '{ST_OK,     8'd1,   16'd1}},
      '{'{REQ_LOOKUP, 8'd0,   16'd1,     1'b0}, 1'b1, '{ST_OK,     8'd0,   16'd1}},
      // generation zero never names a live entry
      '{'{REQ_LOOKUP, 8'd0,   16'd0,     1'b0}, 1'b1, '{ST_STALE,  8'd0,   16'd0}},
      '{'{REQ_LOOKUP, 8'd1,   16'd2,     1'b0}, 1'b1, '{ST_STALE,  8'd1,   16'd2}},
      // slot above the high-water mark
      '{'{REQ_LOOKUP, 8'd2,   16'd1,     1'b0}, 1'b1, '{ST_STALE,  8'd2,   16'd1}},
      '{'{REQ_SPARE,  8'd1,   16'd1,     1'b1}, 1'b1, '{ST_OK,     8'd1,   16'd1}},
      // erase refused while attached, and for a wrong generation
      '{'{REQ_ERASE,  8'd0,   16'd1,     1'b1}, 1'b1, '{ST_ATTACHED, 8'd0, 16'd1}},
      '{'{REQ_ERASE,  8'd0,   16'd2,     1'b0}, 1'b1, '{ST_STALE,  8'd0,   16'd2}},
      // good erase echoes the old generation; the handle is then stale
      '{'{REQ_ERASE,  8'd0,   16'd1,     1'b0}, 1'b1, '{ST_OK,     8'd0,   16'd1}},
      '{'{REQ_LOOKUP, 8'd0,   16'd1,     1'b0}, 1'b1, '{ST_STALE,  8'd0,   16'd1}},
      '{'{REQ_ERASE,  8'd0,   16'd1,     1'b0}, 1'b1, '{ST_STALE,  8'd0,   16'd1}},
      '{'{REQ_ERASE,  8'd1,   16'd1,     1'b0}, 1'b1, '{ST_OK,     8'd1,   16'd1}},
      // reuse is LIFO with the advanced generation
      '{'{REQ_CREATE, 8'd0,   16'd0,     1'b0}, 1'b1, '{ST_OK,     8'd1,   16'd2}},
      '{'{REQ_CREATE, 8'd0,   16'd0,     1'b0}, 1'b1, '{ST_OK,     8'd0,   16'd2}},
      '{'{REQ_CREATE, 8'd0,   16'd0,     1'b0}, 1'b1, '{ST_OK,     8'd2,   16'd1}},
      '{'{REQ_LOOKUP, 8'd255, 16'hFFFF,  1'b1}, 1'b1, '{ST_STALE,  8'd255, 16'hFFFF}},
      // create ignores the handle fields; left to the model
      '{'{REQ_CREATE, 8'd255, 16'hFFFF,  1'b1}, 1'b0, '{ST_OK,     8'd0,   16'd0}}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_type;
   logic [SLOT_W-1:0] req_handle_slot;
   logic [GEN_W-1:0]  req_handle_generation;
   logic              req_still_attached;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic [SLOT_W-1:0] rsp_out_slot;
   logic [GEN_W-1:0]  rsp_out_generation;

   generational_handle_allocator_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_handle_slot       (req_handle_slot),
      .req_handle_generation (req_handle_generation),
      .req_still_attached    (req_still_attached),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_out_slot          (rsp_out_slot),
      .rsp_out_generation    (rsp_out_generation)
   );

   // ------------------------------------------------------------------------
   // Handle table model: generation and occupied bit per slot, LIFO free
   // stack, and the count of slots ever handed out.
   // ------------------------------------------------------------------------
   logic [GEN_W-1:0]  slot_gen   [SLOT_COUNT];
   logic              slot_busy  [SLOT_COUNT];
   logic [SLOT_W-1:0] free_slots [SLOT_COUNT];
   int                free_top;
   int                used_slots;

   alloc_rsp_type expected_rsp_q [$];
   int            mismatch_count;
   int            rsp_beats;

   // phase knobs, written by the stimulus process
   int   gap_pct;
   int   stall_pct;
   logic hold_start;
   logic hold_done;
   int   hold_left;

   function automatic void clear_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_gen[i]   = GEN_FIRST;
         slot_busy[i]  = 1'b0;
         free_slots[i] = '0;
      end
      free_top   = 0;
      used_slots = 0;
   endfunction

   function automatic bit handle_is_live(input logic [SLOT_W-1:0] slot,
                                         input logic [GEN_W-1:0] gen);
      return gen != GEN_NONE && int'(slot) < used_slots && slot_busy[slot] &&
             slot_gen[slot] == gen;
   endfunction

   // Applies one request to the model and returns the response it causes.
   function automatic alloc_rsp_type allocator_step(input alloc_req_type r);
      alloc_rsp_type o;
      o.status = ST_OK;
      o.slot   = r.slot;
      o.gen    = r.gen;
      case (r.kind)
         REQ_CREATE: begin
            if (free_top > 0) begin
               free_top--;
               o.slot = free_slots[free_top];
            end else if (used_slots < SLOT_COUNT) begin
               o.slot = SLOT_W'(used_slots);
               used_slots++;
            end else begin
               o.status = ST_EXHAUSTED;
            end
            if (o.status == ST_OK) begin
               slot_busy[o.slot] = 1'b1;
               o.gen = slot_gen[o.slot];
            end else begin
               o.slot = '0;
               o.gen  = '0;
            end
         end
         REQ_ERASE: begin
            if (!handle_is_live(r.slot, r.gen)) begin
               o.status = ST_STALE;
            end else if (r.attached) begin
               o.status = ST_ATTACHED;
            end else begin
               // wraps past all ones back to one, never zero
               slot_gen[r.slot] = slot_gen[r.slot] + 1'b1;
               if (slot_gen[r.slot] == GEN_NONE) begin
                  slot_gen[r.slot] = GEN_FIRST;
               end
               slot_busy[r.slot] = 1'b0;
               if (free_top < SLOT_COUNT) begin
                  free_slots[free_top] = r.slot;
                  free_top++;
               end
            end
         end
         default: begin
            // lookup, and the spare code
            if (!handle_is_live(r.slot, r.gen)) begin
               o.status = ST_STALE;
            end
         end
      endcase
      return o;
   endfunction

   // random occupied slot, or -1 if none
   function automatic int find_live_slot();
      int first;
      int idx;
      if (used_slots == 0) begin
         return -1;
      end
      first = $urandom_range(used_slots - 1);
      for (int k = 0; k < used_slots; k++) begin
         idx = (first + k) % used_slots;
         if (slot_busy[idx]) begin
            return idx;
         end
      end
      return -1;
   endfunction

   // Mostly well-formed traffic: creates, erases and lookups of live handles,
   // some stale handles (old generation, freed slot, generation zero) and a
   // little pure noise across all four request codes.
   function automatic alloc_req_type random_request(input int create_pct,
                                                    input int erase_pct);
      alloc_req_type r;
      int            pick;
      int            live;
      int            s;
      r.kind     = REQ_CREATE;
      r.slot     = SLOT_W'($urandom);
      r.gen      = GEN_W'($urandom);
      r.attached = 1'($urandom);
      pick       = $urandom_range(99);
      live       = find_live_slot();
      if (pick < create_pct) begin
         return r;
      end
      if (pick < create_pct + erase_pct + 10) begin
         // live handle: erase (sometimes still attached) or lookup
         r.kind = (pick < create_pct + erase_pct) ? REQ_ERASE : REQ_LOOKUP;
         r.attached = ($urandom_range(3) == 0);
         if (live >= 0) begin
            r.slot = SLOT_W'(live);
            r.gen  = slot_gen[live];
         end
      end else if (pick < 92) begin
         r.kind = $urandom_range(1) ? REQ_LOOKUP : REQ_ERASE;
         if (used_slots > 0) begin
            s      = $urandom_range(used_slots - 1);
            r.slot = SLOT_W'(s);
            case ($urandom_range(2))
               0:       r.gen = slot_gen[s];
               1:       r.gen = slot_gen[s] - 1'b1;
               default: r.gen = GEN_NONE;
            endcase
         end
      end else begin
         r.kind = 2'($urandom_range(3));
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("%0t MISMATCH %s", $realtime, msg);
   endtask

   // Offers one request beat, holds it until accepted, then queues the
   // expected response (typed in, or from the model).
   task automatic send_req(input alloc_req_type r, input logic typed,
                           input alloc_rsp_type typed_rsp);
      alloc_rsp_type e;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_type              <= r.kind;
      req_handle_slot       <= r.slot;
      req_handle_generation <= r.gen;
      req_still_attached    <= r.attached;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      e = allocator_step(r);
      if (typed) begin
         e = typed_rsp;
      end
      expected_rsp_q = {expected_rsp_q, e};
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Response side: checks accepted beats against the oldest expectation and
   // drives rsp_stall. One long hold-off lets the pipe fill and back up.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_beats++;
            if (expected_rsp_q.size() == 0) begin
               flag_mismatch($sformatf("beat %0d: response with none pending",
                                       rsp_beats));
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  flag_mismatch($sformatf("beat %0d: status %0d, expected %0d",
                                          rsp_beats, rsp_status, exp_rsp.status));
               end
               if (rsp_out_slot !== exp_rsp.slot) begin
                  flag_mismatch($sformatf("beat %0d: slot %0d, expected %0d",
                                          rsp_beats, rsp_out_slot, exp_rsp.slot));
               end
               if (rsp_out_generation !== exp_rsp.gen) begin
                  flag_mismatch($sformatf("beat %0d: generation %0h, expected %0h",
                                          rsp_beats, rsp_out_generation, exp_rsp.gen));
               end
            end
         end
         if (hold_start && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      alloc_req_type r;
      int            waited;
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_type              <= REQ_CREATE;
      req_handle_slot       <= '0;
      req_handle_generation <= '0;
      req_still_attached    <= 1'b0;
      hold_start            <= 1'b0;
      hold_done      = 1'b0;
      hold_left      = 0;
      gap_pct        = 0;
      stall_pct      = 0;
      mismatch_count = 0;
      rsp_beats      = 0;
      clear_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows, back to back
      foreach (DIR_TABLE[i]) begin
         send_req(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].rsp);
      end

      // fill every slot, then a few creates against the exhausted table
      while (free_top != 0 || used_slots != SLOT_COUNT) begin
         r = '{REQ_CREATE, SLOT_W'($urandom), GEN_W'($urandom), 1'($urandom)};
         send_req(r, 1'b0, '0);
      end
      repeat (3) begin
         r = '{REQ_CREATE, SLOT_W'($urandom), GEN_W'($urandom), 1'($urandom)};
         send_req(r, 1'b0, '0);
      end

      // random phases: even ones drain the table, odd ones refill it
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct   = GAP_PCT[ph];
         stall_pct = STALL_PCT[ph];
         if (ph == 0) begin
            hold_start <= 1'b1;
         end
         repeat (PHASE_ITEMS) begin
            if (ph % 2 == 0) begin
               r = random_request(15, 55);
            end else begin
               r = random_request(55, 15);
            end
            send_req(r, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      waited = 0;
      while (expected_rsp_q.size() != 0 && waited < DRAIN_WAIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_rsp_q.size() != 0) begin
         flag_mismatch($sformatf("%0d responses never arrived",
                                 expected_rsp_q.size()));
      end
      // catch any stray beat after the last expected one
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #4ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
